### hw/rtl/csa_pkg.sv
// shared types and constants for the contiguous slot allocator
// no dependencies; imported by csa_ctrl, csa_datapath and the top level
package csa_pkg;

  // default row size
  localparam int unsigned CSA_SLOTS = 128;

  // request field widths
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned START_W = 7;
  localparam int unsigned POL_W   = 2;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [POL_W-1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } fit_policy_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_SELECT,
    ST_MARK,
    ST_DONE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;     // clear one slot during the power-up pass
    logic req_load;   // latch the request fields
    logic scan_init;  // reset scan pointer and hole tracker
    logic scan_rd;    // read one slot of the bitmap
    logic mark_load;  // load start and length of the run to write
    logic mark_wr;    // write one slot of the run
    logic resp_load;  // load the output register
  } csa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at last slot
    logic is_release; // latched request is a release
    logic len_ok;     // allocate length within 1..SLOTS
    logic mark_skip;  // release touches no slot
    logic scan_last;  // scan reads last slot this cycle
    logic found;      // a hole was selected
    logic mark_last;  // last write of the run
    logic out_free;   // output register can take a result
  } csa_sts_t;

endpackage

### hw/rtl/csa_ctrl.sv
// controller state machine of the slot allocator
// depends on csa_pkg; drives csa_datapath through csa_cmd_t
module csa_ctrl import csa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  csa_sts_t sts_i,
  output csa_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.is_release) begin
          state_d = sts_i.mark_skip ? ST_DONE : ST_MARK;
        end else begin
          state_d = sts_i.len_ok ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_SELECT;
      end
      ST_SELECT: begin
        state_d = sts_i.found ? ST_MARK : ST_DONE;
      end
      ST_MARK: begin
        if (sts_i.mark_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.req_load = in_valid_i;
      end
      ST_DECIDE: begin
        cmd_o.mark_load = sts_i.is_release && !sts_i.mark_skip;
        cmd_o.scan_init = !sts_i.is_release && sts_i.len_ok;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_SELECT: begin
        cmd_o.mark_load = sts_i.found;
      end
      ST_MARK: begin
        cmd_o.mark_wr = 1'b1;
      end
      ST_DONE: begin
        cmd_o.resp_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### hw/rtl/csa_datapath.sv
// datapath of the slot allocator: occupancy memory, hole scan, fit selection
// depends on csa_pkg; controlled by csa_ctrl through csa_cmd_t / csa_sts_t
module csa_datapath import csa_pkg::*; #(
  parameter int unsigned SLOTS = CSA_SLOTS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csa_cmd_t             cmd_i,
  output csa_sts_t             sts_o,
  input  logic                 cfg_we_i,
  input  logic [POL_W-1:0]     cfg_wdata_i,
  input  logic                 operation_i,
  input  logic [LEN_W-1:0]     run_length_i,
  input  logic [START_W-1:0]   release_start_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 granted_o,
  output logic [START_W-1:0]   run_start_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  // configuration
  fit_policy_e pol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= POL_FIRST;
    end else if (cfg_we_i) begin
      pol_q <= fit_policy_e'(cfg_wdata_i);
    end
  end

  // latched request
  op_e                req_op_q;
  logic [LEN_W-1:0]   req_len_q;
  logic [START_W-1:0] req_rs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_op_q  <= op_e'(operation_i);
      req_len_q <= run_length_i;
      req_rs_q  <= release_start_i;
    end
  end

  logic is_release, len_ok, rs_ok;
  assign is_release = (req_op_q == OP_RELEASE);
  assign len_ok     = (req_len_q != '0) && (32'(req_len_q) <= 32'(SLOTS));
  assign rs_ok      = (32'(req_rs_q) < 32'(SLOTS));

  // occupancy memory, one bit per slot
  logic             used_mem [SLOTS];
  logic [IW-1:0]    wr_addr_q, wr_addr_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             mem_we, mem_wval;
  logic [IW-1:0]    rd_addr_q;
  logic [IW-1:0]    rd_idx_q;
  logic             rd_data_q;
  logic             rd_vld_q;

  assign mem_we   = cmd_i.clr_wr || cmd_i.mark_wr;
  assign mem_wval = cmd_i.mark_wr && !is_release;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      used_mem[wr_addr_q] <= mem_wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_data_q <= used_mem[rd_addr_q];
      rd_idx_q  <= rd_addr_q;
    end
  end

  // scan read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_init) begin
        rd_addr_q <= '0;
      end else if (cmd_i.scan_rd) begin
        rd_addr_q <= rd_addr_q + IW'(1);
      end
    end
  end

  // hole tracker: closes a hole at a used slot or at the row end
  logic          in_hole_q;
  logic [IW-1:0] hole_s_q, hole_s_n;
  logic [CW-1:0] hole_h_q, hole_h_n;
  logic          slot_free, at_last;
  logic          cand_vld;
  logic [IW-1:0] cand_s;
  logic [CW-1:0] cand_h;
  logic [CW-1:0] cand_end;
  logic          fit;

  assign slot_free = !rd_data_q;
  assign at_last   = (rd_idx_q == LAST);
  assign hole_s_n  = in_hole_q ? hole_s_q : rd_idx_q;
  assign hole_h_n  = in_hole_q ? (hole_h_q + CW'(1)) : CW'(1);
  assign cand_vld  = rd_vld_q && ((slot_free && at_last) || (!slot_free && in_hole_q));
  assign cand_s    = slot_free ? hole_s_n : hole_s_q;
  assign cand_h    = slot_free ? hole_h_n : hole_h_q;
  assign cand_end  = CW'(cand_s) + cand_h;
  assign fit       = cand_vld && (LW'(cand_h) >= LW'(req_len_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_hole_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      in_hole_q <= 1'b0;
    end else if (rd_vld_q) begin
      in_hole_q <= slot_free && !at_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && slot_free) begin
      hole_s_q <= hole_s_n;
      hole_h_q <= hole_h_n;
    end
  end

  // fit selection
  logic [IW-1:0] ptr_q, ptr_d;
  logic          sel_vld_q, sel_vld_d;
  logic [IW-1:0] sel_s_q, sel_s_d;
  logic [CW-1:0] sel_h_q, sel_h_d;
  logic          any_vld_q, any_vld_d;
  logic [IW-1:0] any_s_q, any_s_d;
  logic          take;

  always_comb begin
    take = 1'b0;
    case (pol_q)
      POL_FIRST: take = fit && !sel_vld_q;
      POL_NEXT:  take = fit && !sel_vld_q && (cand_end > CW'(ptr_q));
      POL_BEST:  take = fit && (!sel_vld_q || (cand_h < sel_h_q));
      POL_WORST: take = fit && (!sel_vld_q || (cand_h > sel_h_q));
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    sel_vld_d = sel_vld_q;
    sel_s_d   = sel_s_q;
    sel_h_d   = sel_h_q;
    any_vld_d = any_vld_q;
    any_s_d   = any_s_q;
    if (cmd_i.req_load) begin
      sel_vld_d = 1'b0;
      any_vld_d = 1'b0;
    end else begin
      if (take) begin
        sel_vld_d = 1'b1;
        sel_s_d   = cand_s;
        sel_h_d   = cand_h;
      end
      // first sufficient hole anywhere, for the next-fit wrap
      if (fit && !any_vld_q) begin
        any_vld_d = 1'b1;
        any_s_d   = cand_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
      any_vld_q <= 1'b0;
    end else begin
      sel_vld_q <= sel_vld_d;
      any_vld_q <= any_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_s_q <= sel_s_d;
    sel_h_q <= sel_h_d;
    any_s_q <= any_s_d;
  end

  logic          found;
  logic [IW-1:0] fin_start;

  assign found     = (pol_q == POL_NEXT) ? (sel_vld_q || any_vld_q) : sel_vld_q;
  assign fin_start = (pol_q == POL_NEXT && !sel_vld_q) ? any_s_q : sel_s_q;

  // next-fit pointer moves past an allocated run
  logic [CW-1:0] ptr_sum;
  assign ptr_sum = CW'(fin_start) + CW'(req_len_q);

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.mark_load && !is_release && pol_q == POL_NEXT) begin
      ptr_d = (ptr_sum == CW'(SLOTS)) ? '0 : IW'(ptr_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // run writer, also walks the clearing pass
  always_comb begin
    wr_addr_d = wr_addr_q;
    rem_d     = rem_q;
    if (cmd_i.mark_load) begin
      wr_addr_d = is_release ? IW'(req_rs_q) : fin_start;
      rem_d     = req_len_q;
    end else if (mem_we) begin
      wr_addr_d = wr_addr_q + IW'(1);
      rem_d     = rem_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_addr_q <= '0;
      rem_q     <= '0;
    end else begin
      wr_addr_q <= wr_addr_d;
      rem_q     <= rem_d;
    end
  end

  // output register
  logic               out_vld_q;
  logic               granted_q;
  logic [START_W-1:0] run_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      granted_q <= is_release || found;
      if (is_release) begin
        run_start_q <= req_rs_q;
      end else begin
        run_start_q <= found ? START_W'(fin_start) : '0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign granted_o   = granted_q;
  assign run_start_o = run_start_q;

  // status back to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (wr_addr_q == LAST);
    sts_o.is_release = is_release;
    sts_o.len_ok     = len_ok;
    sts_o.mark_skip  = (req_len_q == '0) || !rs_ok;
    sts_o.scan_last  = (rd_addr_q == LAST);
    sts_o.found      = found;
    sts_o.mark_last  = (rem_q == LEN_W'(1)) || (wr_addr_q == LAST);
    sts_o.out_free   = !out_vld_q || out_ready_i;
  end

endmodule

### hw/rtl/contiguous_slot_allocator_core.sv
// top level of the contiguous slot allocator
// depends on csa_pkg, csa_ctrl and csa_datapath

// Keeps a one-bit-per-slot occupancy map of SLOTS slots in a memory with
// one read and one write port and places runs by first, next, best or
// worst fit (fit_policy). After reset the map is cleared one slot per
// cycle, so the block takes no request until the clearing pass is done.
// An allocate reads the whole map one slot per cycle and then writes the
// run one slot per cycle; when no hole is large enough it writes nothing,
// and an allocate of length 0 or above SLOTS is refused without a scan.
// A release writes its run only, clipped at the last slot, and writes
// nothing when it touches no slot. One request is in flight at a time; a
// result waits in an output register while the next request is taken.
module contiguous_slot_allocator_core import csa_pkg::*; #(
  parameter int unsigned SLOTS = CSA_SLOTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [POL_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [LEN_W-1:0]   run_length_i,
  input  logic [START_W-1:0] release_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               granted_o,
  output logic [START_W-1:0] run_start_o
);

  csa_cmd_t cmd;
  csa_sts_t sts;

  // sequencer
  csa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // bitmap, scan and result
  csa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .operation_i     (operation_i),
    .run_length_i    (run_length_i),
    .release_start_i (release_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .granted_o       (granted_o),
    .run_start_o     (run_start_o)
  );

endmodule
